/* sv/civil_datetime_to_epoch_macros.svh */
// Assertion macros for the checks in the top-level file of this block.
`ifndef CIVIL_DATETIME_TO_EPOCH_MACROS_SVH
`define CIVIL_DATETIME_TO_EPOCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CDTE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CDTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/cdte_pkg.sv */
package cdte_pkg;

	localparam int unsigned YEAR_MIN        = 2000;
	localparam int unsigned YEAR_MAX        = 2099;
	localparam int unsigned FEB_COMMON_DAYS = 28;
	localparam int unsigned DAYS_PER_YEAR   = 365;
	localparam int unsigned DAYS_TO_2000    = 10957;
	localparam int unsigned SECS_PER_DAY    = 86400;
	localparam int unsigned SECS_PER_HOUR   = 3600;
	localparam int unsigned SECS_PER_MIN    = 60;
	localparam int unsigned MONTH_FEB       = 2;

	localparam int YOFF_W = 7;
	localparam int DAYS_W = 16;
	localparam int SOD_W  = 17;
	localparam int SECS_W = 32;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} item_t;

	typedef struct packed {
		logic              ok;
		logic              leap;
		logic [YOFF_W-1:0] yoff;
		logic [3:0]        month;
		logic [4:0]        day;
		logic [4:0]        hour;
		logic [5:0]        minute;
		logic [5:0]        second;
	} chk_t;

	typedef struct packed {
		logic              ok;
		logic [DAYS_W-1:0] days;
		logic [SOD_W-1:0]  sod;
	} day_t;

	// Length of a month; February follows the leap flag.
	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		unique case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
			4'd2: len = leap ? 5'd29 : 5'(FEB_COMMON_DAYS);
			default:                                   len = 5'd0;
		endcase
		return len;
	endfunction

	// Days in a common year before the first of the month.
	function automatic logic [8:0] days_before(input logic [3:0] month);
		logic [8:0] d;
		unique case (month)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

/* sv/cdte_check.sv */
// First stage: range checks, leap flag and year offset from 2000.
module cdte_check import cdte_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  in_valid,
	input  item_t item,
	output logic  v_s1,
	output chk_t  chk_s1
);

	logic       year_ok;
	logic       leap;
	logic [11:0] yoff_full;
	chk_t       chk;

	always_comb begin
		year_ok   = (item.year >= 12'(YEAR_MIN)) && (item.year <= 12'(YEAR_MAX));
		yoff_full = item.year - 12'(YEAR_MIN);
		// Inside 2000..2099 the full Gregorian rule reduces to divisibility by four.
		leap      = (yoff_full[1:0] == 2'd0);
		chk.leap   = leap;
		chk.yoff   = yoff_full[YOFF_W-1:0];
		chk.month  = item.month;
		chk.day    = item.day;
		chk.hour   = item.hour;
		chk.minute = item.minute;
		chk.second = item.second;
		chk.ok     = year_ok && (item.month >= 4'd1) && (item.month <= 4'd12)
			&& (item.day != 5'd0) && (item.day <= month_days(item.month, leap))
			&& (item.hour < 5'd24) && (item.minute < 6'd60) && (item.second < 6'd60);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			chk_s1 <= chk;
		end
	end

endmodule

/* sv/cdte_days.sv */
// Second stage: day count since 1970-01-01 and seconds into the day.
module cdte_days import cdte_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  logic v_s1,
	input  chk_t chk_s1,
	output logic v_s2,
	output day_t day_s2
);

	logic [DAYS_W-1:0] leap_days;
	logic              late_leap;
	day_t              d;

	always_comb begin
		// Leap years from 2000 up to the year before this one.
		leap_days = DAYS_W'((DAYS_W'(chk_s1.yoff) + DAYS_W'(3)) >> 2);
		late_leap = chk_s1.leap && (chk_s1.month > 4'(MONTH_FEB));
		d.ok   = chk_s1.ok;
		d.days = DAYS_W'(DAYS_TO_2000)
			+ DAYS_W'(chk_s1.yoff) * DAYS_W'(DAYS_PER_YEAR)
			+ leap_days
			+ DAYS_W'(days_before(chk_s1.month))
			+ DAYS_W'(late_leap)
			+ DAYS_W'(chk_s1.day) - DAYS_W'(1);
		d.sod  = SOD_W'(chk_s1.hour) * SOD_W'(SECS_PER_HOUR)
			+ SOD_W'(chk_s1.minute) * SOD_W'(SECS_PER_MIN)
			+ SOD_W'(chk_s1.second);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			day_s2 <= d;
		end
	end

endmodule

/* sv/cdte_scale.sv */
// Third and fourth stages: days times seconds per day, then add the time of
// day and clear the result for an invalid date.
module cdte_scale import cdte_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              v_s2,
	input  day_t              day_s2,
	output logic              v_s4,
	output logic              ok_s4,
	output logic [SECS_W-1:0] secs_s4
);

	logic [DAYS_W+SOD_W-1:0] prod;
	logic                    v_s3;
	logic                    ok_s3;
	logic [SECS_W-1:0]       prod_s3;
	logic [SOD_W-1:0]        sod_s3;

	assign prod = (DAYS_W+SOD_W)'(day_s2.days) * (DAYS_W+SOD_W)'(SECS_PER_DAY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s3   <= day_s2.ok;
			prod_s3 <= prod[SECS_W-1:0];
			sod_s3  <= day_s2.sod;
			ok_s4   <= ok_s3;
			secs_s4 <= ok_s3 ? (prod_s3 + SECS_W'(sod_s3)) : '0;
		end
	end

endmodule

/* sv/civil_datetime_to_epoch.sv */
// Civil date and time to Unix epoch seconds.
// Input channel s_*: one item per date, s_tdata carries year, month, day, hour,
// minute and second. Output channel m_*: one item per input item, m_tdata is the
// epoch second count and m_tuser[0] is the date-valid flag; an invalid date
// gives a zero count with the flag low.
// The datapath is four register stages: range checks, day count and time of day,
// the multiply by seconds per day, and the final add. An accepted item moves through
// the stage registers in order; m_tvalid is the valid bit of the last one, and the
// item leaves when m_tready is high. The block takes one item per clock cycle in
// steady state while the output is not stalled.
// A stall on m_tready freezes all four stages together. A one-item skid register
// at the input catches an item that arrives in the cycle the stall begins, so
// s_tready is a register output and never depends on m_tready in the same cycle.
// Reset clears all valid bits and the skid full flag; the first item may be
// accepted in the first cycle after reset is released.
`include "civil_datetime_to_epoch_macros.svh"

module civil_datetime_to_epoch import cdte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// From bit 0: year_value[11:0], month_value[3:0], day_value[4:0],
	// hour_value[4:0], minute_value[5:0], second_value[5:0], two unused bits.
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// From bit 0: epoch_seconds[31:0].
	output logic [31:0] m_tdata,
	// From bit 0: date_ok.
	output logic [0:0]  m_tuser
);

	item_t in_item;
	item_t skid_q;
	item_t stage_in;
	logic  skid_full_q;
	logic  adv;
	logic  in_valid;
	logic  v_s1;
	logic  v_s2;
	logic  v_s4;
	logic  ok_s4;
	chk_t  chk_s1;
	day_t  day_s2;
	logic [SECS_W-1:0] secs_s4;

	always_comb begin
		in_item.year   = s_tdata[11:0];
		in_item.month  = s_tdata[15:12];
		in_item.day    = s_tdata[20:16];
		in_item.hour   = s_tdata[25:21];
		in_item.minute = s_tdata[31:26];
		in_item.second = s_tdata[37:32];
	end

	// The pipe moves whenever the output register is empty or being drained.
	assign adv      = !v_s4 || m_tready;
	assign s_tready = !skid_full_q;
	// A held item always goes first; while it is held no new item is taken.
	assign in_valid = skid_full_q || s_tvalid;
	assign stage_in = skid_full_q ? skid_q : in_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_full_q <= 1'b0;
		end else if (adv) begin
			skid_full_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!adv && s_tvalid && s_tready) begin
			skid_q <= in_item;
		end
	end

	cdte_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (in_valid),
		.item     (stage_in),
		.v_s1     (v_s1),
		.chk_s1   (chk_s1)
	);

	cdte_days u_days (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_s1   (v_s1),
		.chk_s1 (chk_s1),
		.v_s2   (v_s2),
		.day_s2 (day_s2)
	);

	cdte_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.v_s2    (v_s2),
		.day_s2  (day_s2),
		.v_s4    (v_s4),
		.ok_s4   (ok_s4),
		.secs_s4 (secs_s4)
	);

	assign m_tvalid   = v_s4;
	assign m_tdata    = secs_s4;
	assign m_tuser[0] = ok_s4;

	// An invalid date must come out as a zero count.
	`CDTE_ASSERT_NOW(a_invalid_zero, m_tvalid && !m_tuser[0], m_tdata == 32'd0,
		"invalid date with nonzero seconds")
	// A valid date never lands past the end of 2099.
	`CDTE_ASSERT_NOW(a_valid_range, m_tvalid && m_tuser[0], m_tdata <= 32'd4102444799,
		"epoch seconds out of range")
	// An item taken during a stall must be held in the skid register.
	`CDTE_ASSERT_NEXT(a_skid_catch, s_tvalid && s_tready && !adv, skid_full_q,
		"item accepted during stall was not held")

endmodule
